// ----- hdl/i2c_master_bit_engine_assert.svh -----
// Assertion macros for the I2C master bit engine.
// Used by the checker; no other dependencies.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define I2CMBE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define I2CMBE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/i2cmbe_pkg.sv -----
// Shared types and constants for the I2C master bit engine.
// No dependencies; i2c_master_bit_engine, i2cmbe_csr and i2cmbe_core import this package.
package i2cmbe_pkg;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_TICKS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT = 1'd1;

   localparam logic [15:0] DELAY_TICKS_RESET = 16'd5;
   localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

   localparam logic [3:0] BYTE_BITS = 4'd8;

   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_START     = 3'd1;
   localparam logic [2:0] OP_STOP      = 3'd2;
   localparam logic [2:0] OP_SEND_BYTE = 3'd3;
   localparam logic [2:0] OP_READ_BYTE = 3'd4;
   localparam logic [2:0] OP_WAIT_ACK  = 3'd5;
   localparam logic [2:0] OP_ACK_BIT   = 3'd6;

   typedef enum logic [13:0] {
      PH_IDLE    = 14'h0001,
      PH_START_A = 14'h0002,
      PH_START_B = 14'h0004,
      PH_STOP_A  = 14'h0008,
      PH_STOP_B  = 14'h0010,
      PH_SEND_HI = 14'h0020,
      PH_SEND_LO = 14'h0040,
      PH_READ_LO = 14'h0080,
      PH_READ_HI = 14'h0100,
      PH_WA_A    = 14'h0200,
      PH_WA_B    = 14'h0400,
      PH_WA_POLL = 14'h0800,
      PH_ACK_A   = 14'h1000,
      PH_ACK_B   = 14'h2000
   } phase_type;

   typedef struct packed {
      logic [15:0] delay_ticks;
      logic [7:0]  ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_enable;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_error;
   } rsp_type;

endpackage

// ----- hdl/i2cmbe_if.sv -----
// Valid/ready channel interfaces for the I2C master bit engine.
// No dependencies.
interface i2cmbe_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] tx_byte;
   logic       send_ack;
   logic       sda_sample;

   modport source (output valid, output opcode, output tx_byte, output send_ack,
                   output sda_sample, input ready);
   modport sink   (input valid, input opcode, input tx_byte, input send_ack,
                   input sda_sample, output ready);
endinterface

interface i2cmbe_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       sda_enable;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_error;

   modport source (output valid, output scl_level, output sda_level, output sda_enable,
                   output busy_res, output done_res, output rx_byte, output ack_error,
                   input ready);
   modport sink   (input valid, input scl_level, input sda_level, input sda_enable,
                   input busy_res, input done_res, input rx_byte, input ack_error,
                   output ready);
endinterface

// ----- hdl/i2c_master_bit_engine.sv -----
// Top level of the I2C master bit engine: input register, phase sequencer,
// result register and configuration registers. Depends on i2cmbe_pkg,
// i2cmbe_if, i2cmbe_csr and i2cmbe_core.
//
//   Channel   Direction  Handshake           Carries
//   req_bus   in         valid/ready         opcode, tx_byte, send_ack, sda_sample
//   rsp_bus   out        valid/ready         scl/sda drive, busy, done, rx_byte, error
//   csr_*     in         write enable only   delay_ticks (0), ack_timeout (1)
//
// Each tick goes through two registers: the input register, then the result
// register. One tick is taken every cycle while the result side does not
// stall; the next-state logic of the phase sequencer is combinational.
// Reset is synchronous and active high and returns the sequencer to idle
// with SCL and SDA high and SDA enabled. A stalled result holds the input
// register, which in turn drops req_bus.ready.
module i2c_master_bit_engine (
   input  logic                               clock,
   input  logic                               reset,
   i2cmbe_req_if.sink                         req_bus,
   i2cmbe_rsp_if.source                       rsp_bus,
   input  logic                               csr_wen,
   input  logic [i2cmbe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [i2cmbe_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import i2cmbe_pkg::*;

   cfg_type cfg;
   req_type in_data_ff;
   logic    in_valid_ff;
   logic    in_valid_in;
   rsp_type rsp_data_ff;
   rsp_type step_result;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    step_en;
   logic    take_req;

   // The sequencer steps when the input register holds a tick and the
   // result register is empty or its transfer completes this cycle.
   assign step_en  = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign take_req = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !in_valid_ff || step_en;

   assign in_valid_in  = take_req || (in_valid_ff && !step_en);
   assign rsp_valid_in = step_en || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load on their own transfer and need no reset.
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_data_ff.opcode     <= req_bus.opcode;
         in_data_ff.tx_byte    <= req_bus.tx_byte;
         in_data_ff.send_ack   <= req_bus.send_ack;
         in_data_ff.sda_sample <= req_bus.sda_sample;
      end
      if (step_en) begin
         rsp_data_ff <= step_result;
      end
   end

   i2cmbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cmbe_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .cmd     (in_data_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.scl_level  = rsp_data_ff.scl_level;
   assign rsp_bus.sda_level  = rsp_data_ff.sda_level;
   assign rsp_bus.sda_enable = rsp_data_ff.sda_enable;
   assign rsp_bus.busy_res   = rsp_data_ff.busy_res;
   assign rsp_bus.done_res   = rsp_data_ff.done_res;
   assign rsp_bus.rx_byte    = rsp_data_ff.rx_byte;
   assign rsp_bus.ack_error  = rsp_data_ff.ack_error;

endmodule

// ----- hdl/i2cmbe_csr.sv -----
// Configuration registers of the I2C master bit engine.
// Depends on i2cmbe_pkg.
module i2cmbe_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wen,
   input  logic [i2cmbe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [i2cmbe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output i2cmbe_pkg::cfg_type                cfg
);
   import i2cmbe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_DELAY_TICKS: cfg_in.delay_ticks = csr_wdata;
            CSR_ACK_TIMEOUT: cfg_in.ack_timeout = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_ticks <= DELAY_TICKS_RESET;
         cfg_ff.ack_timeout <= ACK_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/i2cmbe_core.sv -----
// Bus phase sequencer of the I2C master bit engine: state registers and
// the per-tick next-state logic. Depends on i2cmbe_pkg.
module i2cmbe_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  i2cmbe_pkg::req_type cmd,
   input  i2cmbe_pkg::cfg_type cfg,
   output i2cmbe_pkg::rsp_type result
);
   import i2cmbe_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] delay_count_ff, delay_count_in;
   logic [7:0]  poll_count_ff, poll_count_in;
   logic        ack_choice_ff, ack_choice_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        sda_oe_ff, sda_oe_in;
   logic [7:0]  rx_ff, rx_in;
   logic        error_ff, error_in;
   logic        done;

   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      delay_count_in = delay_count_ff;
      poll_count_in  = poll_count_ff;
      ack_choice_in  = ack_choice_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      sda_oe_in      = sda_oe_ff;
      rx_in          = rx_ff;
      error_in       = error_ff;
      done           = 1'b0;

      if (phase_ff == PH_IDLE) begin
         // A command is only taken while idle.
         case (cmd.opcode)
            OP_START: begin
               sda_oe_in = 1'b1; sda_in = 1'b1; scl_in = 1'b1;
               phase_in = PH_START_A; delay_count_in = cfg.delay_ticks;
            end
            OP_STOP: begin
               sda_oe_in = 1'b1; scl_in = 1'b0; sda_in = 1'b0;
               phase_in = PH_STOP_A; delay_count_in = cfg.delay_ticks;
            end
            OP_SEND_BYTE: begin
               sda_oe_in = 1'b1;
               sda_in = cmd.tx_byte[7];
               shift_in = {cmd.tx_byte[6:0], 1'b0};
               bit_count_in = 4'd1;
               scl_in = 1'b1;
               phase_in = PH_SEND_HI; delay_count_in = cfg.delay_ticks;
            end
            OP_READ_BYTE: begin
               sda_oe_in = 1'b0; scl_in = 1'b0;
               shift_in = 8'd0; bit_count_in = 4'd0;
               ack_choice_in = cmd.send_ack;
               phase_in = PH_READ_LO; delay_count_in = cfg.delay_ticks;
            end
            OP_WAIT_ACK: begin
               sda_oe_in = 1'b0; sda_in = 1'b1; error_in = 1'b0;
               phase_in = PH_WA_A; delay_count_in = cfg.delay_ticks;
            end
            OP_ACK_BIT: begin
               ack_choice_in = cmd.send_ack;
               scl_in = 1'b0; sda_oe_in = 1'b1; sda_in = ~cmd.send_ack;
               phase_in = PH_ACK_A; delay_count_in = cfg.delay_ticks;
            end
            default: ;
         endcase
      end else if (phase_ff == PH_WA_POLL) begin
         if (!cmd.sda_sample) begin
            scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
         end else if (poll_count_ff >= cfg.ack_timeout) begin
            // Timed out: flag it and run a full stop condition.
            error_in = 1'b1;
            sda_oe_in = 1'b1; scl_in = 1'b0; sda_in = 1'b0;
            phase_in = PH_STOP_A; delay_count_in = cfg.delay_ticks;
         end else begin
            poll_count_in = poll_count_ff + 8'd1;
         end
      end else if (delay_count_ff > 16'd1) begin
         delay_count_in = delay_count_ff - 16'd1;
      end else begin
         case (phase_ff)
            PH_START_A: begin
               sda_in = 1'b0;
               phase_in = PH_START_B; delay_count_in = cfg.delay_ticks;
            end
            PH_START_B: begin
               scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
            end
            PH_STOP_A: begin
               scl_in = 1'b1; sda_in = 1'b1;
               phase_in = PH_STOP_B; delay_count_in = cfg.delay_ticks;
            end
            PH_STOP_B: begin
               phase_in = PH_IDLE; done = 1'b1;
            end
            PH_SEND_HI: begin
               scl_in = 1'b0;
               phase_in = PH_SEND_LO; delay_count_in = cfg.delay_ticks;
            end
            PH_SEND_LO: begin
               if (bit_count_ff < BYTE_BITS) begin
                  sda_in = shift_ff[7];
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_count_in = bit_count_ff + 4'd1;
                  scl_in = 1'b1;
                  phase_in = PH_SEND_HI; delay_count_in = cfg.delay_ticks;
               end else begin
                  phase_in = PH_IDLE; done = 1'b1;
               end
            end
            PH_READ_LO: begin
               // Sample on the tick that SCL rises.
               scl_in = 1'b1;
               shift_in = {shift_ff[6:0], cmd.sda_sample};
               bit_count_in = bit_count_ff + 4'd1;
               phase_in = PH_READ_HI; delay_count_in = cfg.delay_ticks;
            end
            PH_READ_HI: begin
               if (bit_count_ff < BYTE_BITS) begin
                  scl_in = 1'b0;
                  phase_in = PH_READ_LO; delay_count_in = cfg.delay_ticks;
               end else begin
                  rx_in = shift_ff;
                  scl_in = 1'b0; sda_oe_in = 1'b1; sda_in = ~ack_choice_ff;
                  phase_in = PH_ACK_A; delay_count_in = cfg.delay_ticks;
               end
            end
            PH_WA_A: begin
               scl_in = 1'b1;
               phase_in = PH_WA_B; delay_count_in = cfg.delay_ticks;
            end
            PH_WA_B: begin
               phase_in = PH_WA_POLL; poll_count_in = 8'd0;
            end
            PH_ACK_A: begin
               scl_in = 1'b1;
               phase_in = PH_ACK_B; delay_count_in = cfg.delay_ticks;
            end
            PH_ACK_B: begin
               scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= 4'd0;
         shift_ff       <= 8'd0;
         delay_count_ff <= 16'd0;
         poll_count_ff  <= 8'd0;
         ack_choice_ff  <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         sda_oe_ff      <= 1'b1;
         rx_ff          <= 8'd0;
         error_ff       <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         delay_count_ff <= delay_count_in;
         poll_count_ff  <= poll_count_in;
         ack_choice_ff  <= ack_choice_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         sda_oe_ff      <= sda_oe_in;
         rx_ff          <= rx_in;
         error_ff       <= error_in;
      end
   end

   always_comb begin
      result.scl_level  = scl_in;
      result.sda_level  = sda_in;
      result.sda_enable = sda_oe_in;
      result.busy_res   = (phase_in != PH_IDLE);
      result.done_res   = done;
      result.rx_byte    = rx_in;
      result.ack_error  = error_in;
   end

endmodule

// ----- hdl/i2cmbe_checker.sv -----
// Port-level checks for the I2C master bit engine and their binding.
// Depends on i2c_master_bit_engine_assert.svh and i2c_master_bit_engine.
`include "i2c_master_bit_engine_assert.svh"

module i2cmbe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       scl_level,
   input logic       sda_level,
   input logic       sda_enable,
   input logic       busy_res,
   input logic       done_res,
   input logic [7:0] rx_byte,
   input logic       ack_error
);
   logic [13:0] rsp_word;

   assign rsp_word = {scl_level, sda_level, sda_enable, busy_res, done_res, rx_byte,
                      ack_error};

   // A stalled result keeps its value until it is taken.
   `I2CMBE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "stalled result changed")

   // A command that completes leaves the engine idle.
   `I2CMBE_ASSERT_NOW(a_done_idle, clock, reset, rsp_valid && done_res, !busy_res, "done while still busy")

   // No result is offered in the cycle after reset.
   `I2CMBE_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "result valid after reset")

endmodule

bind i2c_master_bit_engine i2cmbe_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .scl_level  (rsp_bus.scl_level),
   .sda_level  (rsp_bus.sda_level),
   .sda_enable (rsp_bus.sda_enable),
   .busy_res   (rsp_bus.busy_res),
   .done_res   (rsp_bus.done_res),
   .rx_byte    (rsp_bus.rx_byte),
   .ack_error  (rsp_bus.ack_error)
);

// ----- verif/i2cmbe_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the I2C master bit engine: it predicts the line state for every accepted tick
// and compares each result transfer with it. Depends on i2cmbe_pkg and the channel interfaces.

module i2cmbe_scoreboard (
   input  logic                               clock,
   input  logic                               reset,
   i2cmbe_req_if                              req_mon,
   i2cmbe_rsp_if                              rsp_mon,
   input  logic                               csr_wen,
   input  logic [i2cmbe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [i2cmbe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                 errors,
   output int                                 results_seen,
   output int                                 waiting,
   output logic                               engine_busy
);
   import i2cmbe_pkg::*;

   logic [15:0] cfg_delay;
   logic [7:0]  cfg_timeout;

   phase_type   eng_phase;
   logic [3:0]  eng_bits;
   logic [7:0]  eng_shift;
   logic [15:0] eng_delay;
   logic [7:0]  eng_polls;
   logic        eng_ack;
   logic        eng_scl;
   logic        eng_sda;
   logic        eng_oe;
   logic [7:0]  eng_rx;
   logic        eng_err;

   rsp_type line_q[$];

   // Every phase entered through this task reloads the delay counter from the register.
   task automatic enter_phase(input phase_type nxt);
      eng_phase = nxt;
      eng_delay = cfg_delay;
   endtask

   task automatic begin_stop();
      eng_oe  = 1'b1;
      eng_scl = 1'b0;
      eng_sda = 1'b0;
      enter_phase(PH_STOP_A);
   endtask

   task automatic begin_ack_bit();
      eng_scl = 1'b0;
      eng_oe  = 1'b1;
      eng_sda = !eng_ack;
      enter_phase(PH_ACK_A);
   endtask

   task automatic shift_out_bit();
      eng_sda   = eng_shift[7];
      eng_shift = eng_shift << 1;
      eng_bits  = eng_bits + 4'd1;
      eng_scl   = 1'b1;
      enter_phase(PH_SEND_HI);
   endtask

   task automatic predict_tick(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                               input logic sda_in, output rsp_type res);
      logic fin;
      fin = 1'b0;
      if (eng_phase == PH_IDLE) begin
         case (op)
            OP_START: begin
               eng_oe  = 1'b1;
               eng_sda = 1'b1;
               eng_scl = 1'b1;
               enter_phase(PH_START_A);
            end
            OP_STOP: begin_stop();
            OP_SEND_BYTE: begin
               eng_oe    = 1'b1;
               eng_shift = tx;
               eng_bits  = 4'd0;
               shift_out_bit();
            end
            OP_READ_BYTE: begin
               eng_oe    = 1'b0;
               eng_scl   = 1'b0;
               eng_shift = 8'h00;
               eng_bits  = 4'd0;
               eng_ack   = ack;
               enter_phase(PH_READ_LO);
            end
            OP_WAIT_ACK: begin
               eng_oe  = 1'b0;
               eng_sda = 1'b1;
               eng_err = 1'b0;
               enter_phase(PH_WA_A);
            end
            OP_ACK_BIT: begin
               eng_ack = ack;
               begin_ack_bit();
            end
            default: ;
         endcase
      end else if (eng_phase == PH_WA_POLL) begin
         // A low sample is the slave ACK; too many high samples abort with a stop.
         if (!sda_in) begin
            eng_scl   = 1'b0;
            eng_phase = PH_IDLE;
            fin       = 1'b1;
         end else if (eng_polls >= cfg_timeout) begin
            eng_err = 1'b1;
            begin_stop();
         end else begin
            eng_polls = eng_polls + 8'd1;
         end
      end else if (eng_delay > 16'd1) begin
         eng_delay = eng_delay - 16'd1;
      end else begin
         case (eng_phase)
            PH_START_A: begin
               eng_sda = 1'b0;
               enter_phase(PH_START_B);
            end
            PH_START_B: begin
               eng_scl   = 1'b0;
               eng_phase = PH_IDLE;
               fin       = 1'b1;
            end
            PH_STOP_A: begin
               eng_scl = 1'b1;
               eng_sda = 1'b1;
               enter_phase(PH_STOP_B);
            end
            PH_STOP_B: begin
               eng_phase = PH_IDLE;
               fin       = 1'b1;
            end
            PH_SEND_HI: begin
               eng_scl = 1'b0;
               enter_phase(PH_SEND_LO);
            end
            PH_SEND_LO: begin
               if (eng_bits < BYTE_BITS) begin
                  shift_out_bit();
               end else begin
                  eng_phase = PH_IDLE;
                  fin       = 1'b1;
               end
            end
            PH_READ_LO: begin
               eng_scl   = 1'b1;
               eng_shift = {eng_shift[6:0], sda_in};
               eng_bits  = eng_bits + 4'd1;
               enter_phase(PH_READ_HI);
            end
            PH_READ_HI: begin
               if (eng_bits < BYTE_BITS) begin
                  eng_scl = 1'b0;
                  enter_phase(PH_READ_LO);
               end else begin
                  eng_rx = eng_shift;
                  begin_ack_bit();
               end
            end
            PH_WA_A: begin
               eng_scl = 1'b1;
               enter_phase(PH_WA_B);
            end
            PH_WA_B: begin
               eng_phase = PH_WA_POLL;
               eng_polls = 8'd0;
            end
            PH_ACK_A: begin
               eng_scl = 1'b1;
               enter_phase(PH_ACK_B);
            end
            PH_ACK_B: begin
               eng_scl   = 1'b0;
               eng_phase = PH_IDLE;
               fin       = 1'b1;
            end
            default: eng_phase = PH_IDLE;
         endcase
      end
      res.scl_level  = eng_scl;
      res.sda_level  = eng_sda;
      res.sda_enable = eng_oe;
      res.busy_res   = (eng_phase != PH_IDLE);
      res.done_res   = fin;
      res.rx_byte    = eng_rx;
      res.ack_error  = eng_err;
   endtask

   task automatic check_field(input string label, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", label, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         cfg_delay    = DELAY_TICKS_RESET;
         cfg_timeout  = ACK_TIMEOUT_RESET;
         eng_phase    = PH_IDLE;
         eng_bits     = 4'd0;
         eng_shift    = 8'h00;
         eng_delay    = 16'd0;
         eng_polls    = 8'd0;
         eng_ack      = 1'b0;
         eng_scl      = 1'b1;
         eng_sda      = 1'b1;
         eng_oe       = 1'b1;
         eng_rx       = 8'h00;
         eng_err      = 1'b0;
         line_q.delete();
         errors       = 0;
         results_seen = 0;
      end else begin
         // The result side is handled first so that a stray result is never matched
         // against an expectation pushed in the same cycle.
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            if (line_q.size() == 0) begin
               $error("result transfer with no expectation waiting");
               errors++;
            end else begin
               want = line_q.pop_front();
               check_field("scl_level", want.scl_level, rsp_mon.scl_level);
               check_field("sda_level", want.sda_level, rsp_mon.sda_level);
               check_field("sda_enable", want.sda_enable, rsp_mon.sda_enable);
               check_field("busy_res", want.busy_res, rsp_mon.busy_res);
               check_field("done_res", want.done_res, rsp_mon.done_res);
               check_field("rx_byte", want.rx_byte, rsp_mon.rx_byte);
               check_field("ack_error", want.ack_error, rsp_mon.ack_error);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_tick(req_mon.opcode, req_mon.tx_byte, req_mon.send_ack,
                         req_mon.sda_sample, got);
            line_q.push_back(got);
         end
         if (csr_wen) begin
            if (csr_index == CSR_DELAY_TICKS) cfg_delay = csr_wdata[15:0];
            else if (csr_index == CSR_ACK_TIMEOUT) cfg_timeout = csr_wdata[7:0];
         end
      end
      engine_busy = (eng_phase != PH_IDLE);
      waiting     = line_q.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Top of the I2C master bit engine testbench: clock, reset, tick and command stimulus,
// configuration writes and the verdict. Depends on the RTL, its package and i2cmbe_scoreboard.

module testbench;
   import i2cmbe_pkg::*;

   // The opcode field has one spare code, which the engine must treat as a plain tick.
   localparam logic [2:0] OP_UNUSED = 3'd7;

   localparam int MAX_GAP         = 13;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int QUIET_LIMIT     = 5000;
   localparam int TAIL_CYCLES     = 20;
   localparam int RANDOM_ITEMS    = 500;
   localparam int RANDOM_PHASES   = 5;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Knobs shared by the stimulus processes. The main process owns them, except that the
   // result side clears stall_asked once it has started the long hold-off.
   bit idling         = 1'b1;
   bit sda_stuck_high = 1'b0;
   bit stall_asked    = 1'b0;

   int   req_count = 0;
   int   quiet_cycles = 0;
   int   chk_errors;
   int   results_seen;
   int   chk_waiting;
   logic engine_busy;

   i2cmbe_req_if req_bus ();
   i2cmbe_rsp_if rsp_bus ();

   i2c_master_bit_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   i2cmbe_scoreboard i2c_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .errors       (chk_errors),
      .results_seen (results_seen),
      .waiting      (chk_waiting),
      .engine_busy  (engine_busy)
   );

   always #6 clock = ~clock;

   // Offers one tick and returns at the edge where its transfer takes place. Valid stays
   // high afterwards, so back-to-back ticks go out at full rate when no gap is drawn.
   task automatic send_item(input logic [2:0] op, input logic [7:0] tx, input logic ack);
      int gap;
      gap = idling ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.tx_byte    <= tx;
      req_bus.send_ack   <= ack;
      req_bus.sda_sample <= sda_stuck_high ? 1'b1 : 1'($urandom_range(0, 1));
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      req_count++;
   endtask

   // Sends a command, then ticks until the engine is idle again. The busy flag from the
   // checker may lag by one tick, which only costs an extra tick. Some of the ticks carry
   // a random opcode, so commands also arrive while the engine is busy.
   task automatic issue(input logic [2:0] op, input logic [7:0] tx, input logic ack);
      logic [2:0] filler;
      send_item(op, tx, ack);
      do begin
         filler = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : OP_TICK;
         send_item(filler, 8'($urandom), 1'($urandom_range(0, 1)));
      end while (engine_busy);
   endtask

   // Brings the engine and the pipeline to rest: valid drops, every result is collected,
   // and plain ticks finish any command still running. The busy flag is only trusted once
   // every result is in, since by then the checker has seen every tick.
   task automatic settle_engine();
      forever begin
         req_bus.valid <= 1'b0;
         while (results_seen < req_count) @(posedge clock);
         if (!engine_busy) break;
         do send_item(OP_TICK, 8'h00, 1'b0); while (engine_busy);
      end
   endtask

   // Registers are only written with the engine idle and nothing in flight.
   task automatic configure(input logic [15:0] delay_value, input logic [7:0] timeout_value);
      settle_engine();
      csr_wen   <= 1'b1;
      csr_index <= CSR_DELAY_TICKS;
      csr_wdata <= delay_value;
      @(posedge clock);
      csr_index <= CSR_ACK_TIMEOUT;
      csr_wdata <= CSR_DATA_W'(timeout_value);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // One bus transaction: start, address, ACK wait, up to three data bytes or ACK bits,
   // stop. A few of them skip the stop or see a slave that never pulls SDA low.
   task automatic run_transaction();
      sda_stuck_high = ($urandom_range(0, 9) == 0);
      issue(OP_START, 8'($urandom), 1'($urandom_range(0, 1)));
      issue(OP_SEND_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
      issue(OP_WAIT_ACK, 8'($urandom), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 2))
            0: begin
               issue(OP_SEND_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
               issue(OP_WAIT_ACK, 8'($urandom), 1'($urandom_range(0, 1)));
            end
            1: issue(OP_READ_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
            default: issue(OP_ACK_BIT, 8'($urandom), 1'($urandom_range(0, 1)));
         endcase
      end
      if ($urandom_range(0, 7) != 0) issue(OP_STOP, 8'($urandom), 1'($urandom_range(0, 1)));
      sda_stuck_high = 1'b0;
   endtask

   // Result side. Every result draws its own stall; on request it also holds ready low
   // for a long stretch so that the engine backs up and stalls the tick input.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (stall_asked) begin
            stall_asked = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            stall = idling ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // Watchdog: a correct run never goes long without a transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          phase_base;
      logic [15:0] set_delay;
      logic [7:0]  set_timeout;

      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_TICK;
      req_bus.tx_byte    = 8'h00;
      req_bus.send_ack   = 1'b0;
      req_bus.sda_sample = 1'b1;
      csr_wen            = 1'b0;
      csr_index          = CSR_DELAY_TICKS;
      csr_wdata          = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first at the reset settings: every command, the byte extremes,
      // both ACK choices, the spare opcode and a command that arrives while busy.
      issue(OP_START, 8'h00, 1'b0);
      issue(OP_SEND_BYTE, 8'h00, 1'b0);
      issue(OP_SEND_BYTE, 8'hFF, 1'b1);
      issue(OP_WAIT_ACK, 8'h00, 1'b0);
      issue(OP_READ_BYTE, 8'h00, 1'b1);
      issue(OP_READ_BYTE, 8'hFF, 1'b0);
      issue(OP_ACK_BIT, 8'h00, 1'b1);
      issue(OP_ACK_BIT, 8'h00, 1'b0);
      issue(OP_STOP, 8'h00, 1'b0);
      issue(OP_UNUSED, 8'hA5, 1'b1);
      issue(OP_TICK, 8'h5A, 1'b0);
      send_item(OP_START, 8'h00, 1'b0);
      send_item(OP_SEND_BYTE, 8'h3C, 1'b1);

      // A zero delay must behave like one tick per phase, and with no polls tolerated
      // the first high sample of the ACK wait aborts with a stop.
      configure(16'd0, 8'd0);
      issue(OP_SEND_BYTE, 8'h81, 1'b0);
      sda_stuck_high = 1'b1;
      issue(OP_WAIT_ACK, 8'h00, 1'b0);
      sda_stuck_high = 1'b0;
      issue(OP_READ_BYTE, 8'h00, 1'b1);

      // The longest tolerated ACK wait, run to its timeout.
      configure(16'd1, 8'd255);
      sda_stuck_high = 1'b1;
      issue(OP_WAIT_ACK, 8'h00, 1'b0);
      sda_stuck_high = 1'b0;

      // A long phase delay, on one of the shortest commands, with no idling.
      idling = 1'b0;
      configure(16'd64, 8'd250);
      issue(OP_STOP, 8'h00, 1'b0);
      idling = 1'b1;

      // Random part: several settings, each opened by a long hold-off on the result side.
      // Idling is switched off for some transactions to get full-rate stretches.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin set_delay = 16'd1; set_timeout = 8'd3;   end
            1: begin set_delay = 16'd0; set_timeout = 8'd0;   end
            2: begin set_delay = 16'd2; set_timeout = 8'd255; end
            3: begin set_delay = 16'd3; set_timeout = 8'd1;   end
            default: begin set_delay = 16'd1; set_timeout = 8'd250; end
         endcase
         configure(set_delay, set_timeout);
         stall_asked = 1'b1;
         phase_base  = req_count;
         while (req_count - phase_base < RANDOM_ITEMS / RANDOM_PHASES) begin
            idling = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) == 0) begin
               // Noise: raw ticks with any opcode, regardless of the engine's state.
               repeat ($urandom_range(1, 6))
                  send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
            end else begin
               run_transaction();
            end
         end
      end
      idling = 1'b1;

      settle_engine();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (chk_waiting != 0) $error("%0d expected results never arrived", chk_waiting);
      if (chk_errors == 0 && chk_waiting == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
